// ----- hdl/radial_gradient_param_gen_macros.svh -----
// ---------------------------------------------------------------------------
// Radial gradient parameter generator assertion macros
// Shared forms for the concurrent checks of the block.
// ---------------------------------------------------------------------------
`ifndef RADIAL_GRADIENT_PARAM_GEN_MACROS_SVH
`define RADIAL_GRADIENT_PARAM_GEN_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RGP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RGP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rgp_pkg.sv -----
// ---------------------------------------------------------------------------
// Radial gradient parameter generator package
// Types, register codes and helpers shared by the block's modules.
// ---------------------------------------------------------------------------
package rgp_pkg;

   localparam int SQRT_STEPS = 32;
   localparam logic [31:0] STEP_X_RESET = 32'h0001_0000;

   typedef enum logic [2:0] {
      REG_NEG_FOUR_A = 3'd0,
      REG_INV_HALF_A = 3'd1,
      REG_RADIUS_SQ  = 3'd2,
      REG_ROOT_SIGN  = 3'd3,
      REG_STEP_X     = 3'd4,
      REG_STEP_Y     = 3'd5,
      REG_STEP_B     = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [31:0] neg_four_a;
      logic [31:0] inv_half_a;
      logic [30:0] radius_sq;
      logic        root_sign;
      logic [31:0] step_x;
      logic [31:0] step_y;
      logic [31:0] step_b;
   } cfg_type;

   // Payload handed from one square root cell to the next.
   typedef struct packed {
      logic        vld;
      logic [63:0] rad;
      logic [33:0] rem;
      logic [31:0] root;
      logic [31:0] b;
      logic        le;
   } sq_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      mag32 = v[31] ? (32'd0 - v) : v;
   endfunction

endpackage

// ----- hdl/rgp_front.sv -----
// ---------------------------------------------------------------------------
// Radial gradient discriminant front end
// Holds the scanline state and forms the clamped discriminant in seven stages.
// ---------------------------------------------------------------------------
module rgp_front
   import rgp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  cfg_type      cfg,
   input  logic         in_vld,
   input  logic         line_start,
   input  logic [31:0]  start_pdx,
   input  logic [31:0]  start_pdy,
   input  logic [31:0]  start_b,
   input  logic         line_end,
   output sq_type       q
);

   logic [31:0] cur_pdx_ff, cur_pdy_ff, cur_b_ff;
   logic [31:0] pdx_in, pdy_in, b_in;
   logic [6:0]  vld_ff;

   logic [31:0] s1_pdx_ff, s1_pdy_ff, s1_b_ff;
   logic [6:0]  le_ff;
   logic [31:0] s2_b_ff, s3_b_ff, s4_b_ff, s5_b_ff, s6_b_ff, s7_b_ff;
   logic [63:0] s2_x2_ff, s2_y2_ff, s2_bsq_ff;
   logic [63:0] s3_sum_ff, s3_bsq_ff;
   logic        s4_cneg_ff;
   logic [63:0] s4_cmag_ff, s4_bsq_ff;
   logic        s5_neg_ff;
   logic [63:0] s5_p0_ff, s5_p1_ff, s5_bsq_ff;
   logic        s6_neg_ff;
   logic [95:0] s6_ac_ff, s6_bs_ff;
   logic [63:0] s7_dq_ff;

   logic [63:0] rsq;
   logic [31:0] nfa_mag;
   logic        ac_neg;
   logic [95:0] d;

   assign pdx_in = line_start ? start_pdx : cur_pdx_ff;
   assign pdy_in = line_start ? start_pdy : cur_pdy_ff;
   assign b_in   = line_start ? start_b   : cur_b_ff;

   // The running offsets advance once per accepted pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_pdx_ff <= '0;
         cur_pdy_ff <= '0;
         cur_b_ff   <= '0;
         vld_ff     <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], in_vld};
         if (in_vld) begin
            cur_pdx_ff <= pdx_in + cfg.step_x;
            cur_pdy_ff <= pdy_in + cfg.step_y;
            cur_b_ff   <= b_in + cfg.step_b;
         end
      end
   end

   assign rsq     = {17'd0, cfg.radius_sq, 16'd0};
   assign nfa_mag = mag32(cfg.neg_four_a);
   assign ac_neg  = s6_neg_ff && (s6_ac_ff != '0);

   always_comb begin
      if (!ac_neg) begin
         d = s6_ac_ff + s6_bs_ff;
      end else if (s6_ac_ff >= s6_bs_ff) begin
         d = '0;
      end else begin
         d = s6_bs_ff - s6_ac_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         le_ff      <= {le_ff[5:0], line_end};
         s1_pdx_ff  <= pdx_in;
         s1_pdy_ff  <= pdy_in;
         s1_b_ff    <= b_in;
         s2_x2_ff   <= 64'(mag32(s1_pdx_ff)) * 64'(mag32(s1_pdx_ff));
         s2_y2_ff   <= 64'(mag32(s1_pdy_ff)) * 64'(mag32(s1_pdy_ff));
         s2_bsq_ff  <= 64'(mag32(s1_b_ff)) * 64'(mag32(s1_b_ff));
         s2_b_ff    <= s1_b_ff;
         s3_sum_ff  <= s2_x2_ff + s2_y2_ff;
         s3_bsq_ff  <= s2_bsq_ff;
         s3_b_ff    <= s2_b_ff;
         s4_cneg_ff <= s3_sum_ff < rsq;
         s4_cmag_ff <= (s3_sum_ff < rsq) ? (rsq - s3_sum_ff) : (s3_sum_ff - rsq);
         s4_bsq_ff  <= s3_bsq_ff;
         s4_b_ff    <= s3_b_ff;
         s5_p0_ff   <= 64'(nfa_mag) * 64'(s4_cmag_ff[31:0]);
         s5_p1_ff   <= 64'(nfa_mag) * 64'(s4_cmag_ff[63:32]);
         s5_neg_ff  <= s4_cneg_ff ^ cfg.neg_four_a[31];
         s5_bsq_ff  <= s4_bsq_ff;
         s5_b_ff    <= s4_b_ff;
         s6_ac_ff   <= {32'd0, s5_p0_ff} + {s5_p1_ff, 32'd0};
         s6_bs_ff   <= {16'd0, s5_bsq_ff, 16'd0};
         s6_neg_ff  <= s5_neg_ff;
         s6_b_ff    <= s5_b_ff;
         s7_dq_ff   <= (d[95:80] != '0) ? {64{1'b1}} : d[79:16];
         s7_b_ff    <= s6_b_ff;
      end
   end

   assign q.vld  = vld_ff[6];
   assign q.rad  = s7_dq_ff;
   assign q.rem  = '0;
   assign q.root = '0;
   assign q.b    = s7_b_ff;
   assign q.le   = le_ff[6];

endmodule

// ----- hdl/rgp_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// Radial gradient square root cell
// One restoring step: takes two radicand bits and yields one root bit.
// ---------------------------------------------------------------------------
module rgp_sqrt_cell
   import rgp_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   en,
   input  sq_type d,
   output sq_type q
);

   logic        vld_ff;
   sq_type      pay_ff;
   logic [34:0] rem_sh;
   logic [34:0] trial;
   logic        take;

   assign rem_sh = {d.rem[32:0], d.rad[63:62]};
   assign trial  = {1'b0, d.root, 2'b01};
   assign take   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= d.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pay_ff.vld  <= d.vld;
         pay_ff.rad  <= {d.rad[61:0], 2'b00};
         pay_ff.rem  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
         pay_ff.root <= {d.root[30:0], take};
         pay_ff.b    <= d.b;
         pay_ff.le   <= d.le;
      end
   end

   always_comb begin
      q     = pay_ff;
      q.vld = vld_ff;
   end

endmodule

// ----- hdl/rgp_back.sv -----
// ---------------------------------------------------------------------------
// Radial gradient parameter back end
// Scales b plus or minus the root, rounds to Q16.16 and saturates.
// ---------------------------------------------------------------------------
module rgp_back
   import rgp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  cfg_type      cfg,
   input  sq_type       d,
   output logic         out_vld,
   output logic [31:0]  t_value,
   output logic         end_of_line
);

   logic [2:0]  vld_ff;
   logic [2:0]  le_ff;
   logic [33:0] s;
   logic [32:0] s1_mag_ff;
   logic        s1_neg_ff, s2_neg_ff;
   logic [64:0] s2_mag_ff;
   logic [31:0] t_ff;
   logic [48:0] qt;
   logic [15:0] rm;
   logic [49:0] qr;
   logic [31:0] t_in;

   assign s = cfg.root_sign ? ({{2{d.b[31]}}, d.b} + {2'b00, d.root})
                            : ({{2{d.b[31]}}, d.b} - {2'b00, d.root});

   assign qt = s2_mag_ff[64:16];
   assign rm = s2_mag_ff[15:0];
   assign qr = {1'b0, qt} + 50'((rm > 16'h8000) || ((rm == 16'h8000) && qt[0]));

   always_comb begin
      if (!s2_neg_ff || qr == '0) begin
         t_in = (qr > 50'h7FFF_FFFF) ? 32'h7FFF_FFFF : qr[31:0];
      end else if (qr > 50'h8000_0000) begin
         t_in = 32'h8000_0000;
      end else begin
         t_in = 32'd0 - qr[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], d.vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         le_ff     <= {le_ff[1:0], d.le};
         s1_mag_ff <= s[33] ? 33'(34'd0 - s) : s[32:0];
         s1_neg_ff <= s[33] ^ cfg.inv_half_a[31];
         s2_mag_ff <= 65'(mag32(cfg.inv_half_a)) * 65'(s1_mag_ff);
         s2_neg_ff <= s1_neg_ff;
         t_ff      <= t_in;
      end
   end

   assign out_vld     = vld_ff[2];
   assign t_value     = t_ff;
   assign end_of_line = le_ff[2];

endmodule

// ----- hdl/radial_gradient_param_gen.sv -----
// Throughput: one pixel per cycle while no result is stalled on rsp_tready.
// Stages: 7 front stages, 32 square root cells, 3 back stages.
// The whole pipeline holds while a result waits on rsp_tready.
// Reset clears the running offsets, the valid bits and the registers to their defaults.
// Configuration writes are taken every cycle.
// ---------------------------------------------------------------------------
// Radial gradient parameter generator
// Streams the two-circle gradient parameter t for each pixel of a scanline.
// ---------------------------------------------------------------------------
module radial_gradient_param_gen
   import rgp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // start_pdx, start_pdy, start_b
   input  logic         req_tuser,   // line_start
   input  logic         req_tlast,   // line_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // t_value
   output logic         rsp_tlast,   // end_of_line
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   cfg_type cfg_ff;
   logic    en;
   sq_type  link [SQRT_STEPS+1];

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.neg_four_a <= '0;
         cfg_ff.inv_half_a <= '0;
         cfg_ff.radius_sq  <= '0;
         cfg_ff.root_sign  <= 1'b0;
         cfg_ff.step_x     <= STEP_X_RESET;
         cfg_ff.step_y     <= '0;
         cfg_ff.step_b     <= '0;
      end else if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_NEG_FOUR_A: cfg_ff.neg_four_a <= csr_data;
            REG_INV_HALF_A: cfg_ff.inv_half_a <= csr_data;
            REG_RADIUS_SQ:  cfg_ff.radius_sq  <= csr_data[30:0];
            REG_ROOT_SIGN:  cfg_ff.root_sign  <= csr_data[0];
            REG_STEP_X:     cfg_ff.step_x     <= csr_data;
            REG_STEP_Y:     cfg_ff.step_y     <= csr_data;
            REG_STEP_B:     cfg_ff.step_b     <= csr_data;
            default: ;
         endcase
      end
   end

   rgp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg_ff),
      .in_vld     (req_tvalid),
      .line_start (req_tuser),
      .start_pdx  (req_tdata[31:0]),
      .start_pdy  (req_tdata[63:32]),
      .start_b    (req_tdata[95:64]),
      .line_end   (req_tlast),
      .q          (link[0])
   );

   for (genvar gi = 0; gi < SQRT_STEPS; gi++) begin : g_cell
      rgp_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .d     (link[gi]),
         .q     (link[gi+1])
      );
   end

   rgp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .cfg         (cfg_ff),
      .d           (link[SQRT_STEPS]),
      .out_vld     (rsp_tvalid),
      .t_value     (rsp_tdata),
      .end_of_line (rsp_tlast)
   );

endmodule

// ----- hdl/rgp_checker.sv -----
// ---------------------------------------------------------------------------
// Radial gradient parameter generator port checker
// Watches the ports for flow control slips and binds to the top level.
// ---------------------------------------------------------------------------
`include "radial_gradient_param_gen_macros.svh"

module rgp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_ready
);

   // A stalled result keeps its transfer pending with the same data.
   `RGP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // With no result waiting the pipeline must take input.
   `RGP_ASSERT_SAME(a_ready_idle, clock, reset, !rsp_tvalid, req_tready, "input refused while output empty")

   // A stalled result freezes the whole pipeline, input included.
   `RGP_ASSERT_SAME(a_stall_in, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "input taken during output stall")

   `RGP_ASSERT_SAME(a_csr_ready, clock, reset, 1'b1, csr_ready, "register write refused")

endmodule

bind radial_gradient_param_gen rgp_checker u_rgp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_ready  (csr_ready)
);

// ----- tb/sv/radial_gradient_param_gen_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Radial gradient parameter generator testbench
// Streams scanlines of pixels through the block under several register
// settings and checks every t value and end-of-line flag against a
// behavioral model of the fixed-point gradient arithmetic.
// ---------------------------------------------------------------------------
module radial_gradient_param_gen_tb;
   import rgp_pkg::*;

   localparam int LATENCY   = 41;
   localparam int WDOG_MAX  = 20000;
   localparam int NUM_RAND  = 1800;

   typedef struct packed {
      logic        line_start;
      logic [31:0] pdx;
      logic [31:0] pdy;
      logic [31:0] b;
      logic        line_end;
   } pixel_type;

   typedef struct packed {
      logic [31:0] t_value;
      logic        eol;
   } t_result_type;

   typedef struct {
      pixel_type   pix;
      logic        known;
      logic [31:0] t_value;
   } dir_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic         req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;

   // Predictor copy of the registers and the running offsets.
   logic [31:0] m_neg_four_a, m_inv_half_a, m_step_x, m_step_y, m_step_b;
   logic [30:0] m_radius_sq;
   logic        m_root_sign;
   logic [31:0] m_pdx, m_pdy, m_b;

   t_result_type pending_t[$];
   int           errors;
   int           n_results;
   int           wdog;
   int           rsp_hold;
   bit           stall_rsp_en;

   radial_gradient_param_gen u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] rem, res, bt;
      rem = x;
      res = '0;
      bt  = 64'd1 << 62;
      while (bt > rem) bt = bt >> 2;
      while (bt != 0) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] calc_t_value(input logic [31:0] pdx, input logic [31:0] pdy,
                                                input logic [31:0] b);
      logic [31:0]  mx, my, mb, ma;
      logic [63:0]  sum, rsq, c_mag, dq, root, smag, mag, q, rm;
      logic [127:0] ac, bs, d;
      logic         c_neg, ac_neg, neg;
      logic signed [65:0] bsig, s;
      mx = mag32(pdx);
      my = mag32(pdy);
      mb = mag32(b);
      sum = 64'(mx) * mx + 64'(my) * my;
      rsq = 64'(m_radius_sq) << 16;
      c_neg = sum < rsq;
      c_mag = c_neg ? rsq - sum : sum - rsq;
      ma = mag32(m_neg_four_a);
      ac = 128'(ma) * 128'(c_mag);
      ac_neg = (c_neg != m_neg_four_a[31]) && (ac != 0);
      bs = 128'(64'(mb) * mb) << 16;
      if (!ac_neg) d = ac + bs;
      else if (ac >= bs) d = '0;
      else d = bs - ac;
      dq = (d[127:80] != 0) ? '1 : d[79:16];
      root = floor_sqrt(dq);
      bsig = 66'(signed'(b));
      s = m_root_sign ? bsig + $signed({2'b00, root}) : bsig - $signed({2'b00, root});
      smag = s < 0 ? 64'(-s) : 64'(s);
      mag = 64'(mag32(m_inv_half_a)) * smag;
      neg = m_inv_half_a[31] != (s < 0);
      q = mag >> 16;
      rm = mag & 64'hFFFF;
      if (rm > 64'h8000 || (rm == 64'h8000 && q[0])) q = q + 1;
      if (!neg || q == 0) return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      if (q > 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - q[31:0];
   endfunction

   // Advances the model by one pixel and returns its expected result.
   function automatic t_result_type advance_pixel(input pixel_type p);
      t_result_type r;
      if (p.line_start) begin
         m_pdx = p.pdx;
         m_pdy = p.pdy;
         m_b   = p.b;
      end
      r.t_value = calc_t_value(m_pdx, m_pdy, m_b);
      r.eol = p.line_end;
      m_pdx += m_step_x;
      m_pdy += m_step_y;
      m_b   += m_step_b;
      return r;
   endfunction

   // The request stays valid between back-to-back pixels and drops for a gap or while the sender is held.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (n != 0) req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_NEG_FOUR_A: m_neg_four_a = val;
         REG_INV_HALF_A: m_inv_half_a = val;
         REG_RADIUS_SQ:  m_radius_sq  = val[30:0];
         REG_ROOT_SIGN:  m_root_sign  = val[0];
         REG_STEP_X:     m_step_x     = val;
         REG_STEP_Y:     m_step_y     = val;
         REG_STEP_B:     m_step_b     = val;
         default: ;
      endcase
   endtask

   task automatic hold_until_empty();
      req_tvalid <= 1'b0;
      while (pending_t.size() != 0) @(posedge clock);
   endtask

   task automatic drain();
      hold_until_empty();
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type p, input bit use_gaps, input logic known,
                             input logic [31:0] t_known);
      t_result_type r;
      if (use_gaps) idle_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= p.line_start;
      req_tdata  <= {p.b, p.pdy, p.pdx};
      req_tlast  <= p.line_end;
      do @(posedge clock); while (!req_tready);
      r = advance_pixel(p);
      if (known && r.t_value !== t_known) begin
         $display("%0t: predictor disagrees with table: table %h model %h",
                  $time, t_known, r.t_value);
         errors++;
      end
      pending_t.push_back(r);
   endtask

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom;
         default: return 32'(signed'($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   task automatic rand_setting(input bit wild);
      write_reg(REG_NEG_FOUR_A, wild ? $urandom : 32'(-($urandom_range(1, 8) << 16)));
      write_reg(REG_INV_HALF_A, wild ? $urandom : 32'(signed'($urandom_range(0, 1 << 17))
                                                      - (1 << 16)));
      write_reg(REG_RADIUS_SQ, wild ? $urandom : $urandom_range(0, 16 << 16));
      write_reg(REG_ROOT_SIGN, $urandom);
      write_reg(REG_STEP_X, wild ? $urandom : $urandom_range(0, 1 << 17) - (1 << 16));
      write_reg(REG_STEP_Y, wild ? $urandom : $urandom_range(0, 1 << 15));
      write_reg(REG_STEP_B, wild ? $urandom : $urandom_range(0, 1 << 15) - (1 << 14));
   endtask

   // Result side: random back-pressure once enabled, checks against the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_t.size() == 0) begin
               $display("%0t: unexpected result t=%h eol=%b", $time, rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               if (rsp_tdata !== pending_t[0].t_value || rsp_tlast !== pending_t[0].eol) begin
                  $display("%0t: mismatch expected t=%h eol=%b actual t=%h eol=%b", $time,
                           pending_t[0].t_value, pending_t[0].eol, rsp_tdata, rsp_tlast);
                  errors++;
               end
               void'(pending_t.pop_front());
            end
            n_results++;
         end
         if (!stall_rsp_en) begin
            rsp_tready <= 1'b1;
         end else if (rsp_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_hold - 1;
         end else if ($urandom_range(0, 49) == 0) begin
            // A few long stalls among the short random ones.
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(5, 40);
         end else begin
            rsp_tready <= ($urandom_range(0, 9) < 7);
         end
      end
   end

   // Watchdog: cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         wdog <= 0;
      end else begin
         wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   dir_row_type dir_rows[$];

   initial begin
      pixel_type p;
      int        k, len;
      errors = 0;
      n_results = 0;
      stall_rsp_en = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_NEG_FOUR_A;
      csr_data = '0;
      m_neg_four_a = '0; m_inv_half_a = '0; m_radius_sq = '0; m_root_sign = 1'b0;
      m_step_x = STEP_X_RESET; m_step_y = '0; m_step_b = '0;
      m_pdx = '0; m_pdy = '0; m_b = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: reset registers give t = 0 everywhere; no start is used first.
      dir_rows.push_back('{'{1'b0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, 32'h0});
      dir_rows.push_back('{'{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1},
                           1'b1, 32'h0});
      foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, 1'b0, dir_rows[i].known,
                                       dir_rows[i].t_value);
      drain();
      // A = -1/4, -1/(2A) = 2: with b=0 root of (pdx^2+pdy^2-r^2).
      write_reg(REG_NEG_FOUR_A, 32'h0001_0000);
      write_reg(REG_INV_HALF_A, 32'h0002_0000);
      write_reg(REG_RADIUS_SQ, 32'h0001_0000);
      write_reg(REG_ROOT_SIGN, 32'h1);
      write_reg(REG_STEP_Y, 32'h0000_8000);
      write_reg(REG_STEP_B, 32'h0000_4000);
      dir_rows.delete();
      dir_rows.push_back('{'{1'b1, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0});
      dir_rows.push_back('{'{1'b0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, 32'h0});
      dir_rows.push_back('{'{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
                           1'b0, 32'h0});
      dir_rows.push_back('{'{1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
                           1'b0, 32'h0});
      dir_rows.push_back('{'{1'b1, 32'h0003_0000, 32'h0004_0000, 32'hFFFF_0000, 1'b1},
                           1'b0, 32'h0});
      foreach (dir_rows[i]) send_pixel(dir_rows[i].pix, 1'b0, 1'b0, 32'h0);
      drain();
      // Extreme registers: saturation and step wrap.
      write_reg(REG_NEG_FOUR_A, 32'h7FFF_FFFF);
      write_reg(REG_INV_HALF_A, 32'h8000_0000);
      write_reg(REG_RADIUS_SQ, 32'h7FFF_FFFF);
      write_reg(REG_ROOT_SIGN, 32'h0);
      write_reg(REG_STEP_X, 32'h7FFF_FFFF);
      write_reg(REG_STEP_Y, 32'h8000_0000);
      write_reg(REG_STEP_B, 32'hFFFF_FFFF);
      for (k = 0; k < 6; k++) begin
         p = '{k == 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, k == 5};
         send_pixel(p, 1'b0, 1'b0, 32'h0);
      end
      drain();
      write_reg(REG_NEG_FOUR_A, 32'h8000_0000);
      write_reg(REG_INV_HALF_A, 32'h7FFF_FFFF);
      write_reg(REG_RADIUS_SQ, 32'h0);
      for (k = 0; k < 4; k++) begin
         p = '{k == 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, k == 3};
         send_pixel(p, 1'b0, 1'b0, 32'h0);
      end
      drain();

      // Random scanlines in phases, settings rewritten between phases.
      stall_rsp_en = 1'b1;
      k = 0;
      while (k < NUM_RAND) begin
         rand_setting(($urandom_range(0, 3) == 0));
         repeat (6) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
            for (int j = 0; j < len; j++) begin
               p.line_start = (j == 0) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 30) == 0);
               p.pdx = rand_field();
               p.pdy = rand_field();
               p.b = rand_field();
               p.line_end = (j == len - 1) ? 1'b1 : ($urandom_range(0, 30) == 0);
               send_pixel(p, ($urandom_range(0, 3) != 0), 1'b0, 32'h0);
               k++;
            end
            // Hold the sender until the pipeline is empty now and then.
            if ($urandom_range(0, 4) == 0)
               hold_until_empty();
         end
         drain();
      end

      drain();
      $display("Checked %0d results over %0d random pixels and directed corner lines.",
               n_results, k);
      $display("Register settings included reset defaults, extremes and random values.");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
